@@ rtl/vlff_pkg.sv @@
package vlff_pkg;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_WIPE,
		ST_SEED_RD,
		ST_SEED_CHK,
		ST_POP,
		ST_ENTRY,
		ST_NB_RD,
		ST_NB_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} q_ctl_t;

	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_COMPUTE = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;

	localparam logic [1:0] CFG_EMITTER_ID    = 2'd0;
	localparam logic [1:0] CFG_EMITTER_LEVEL = 2'd1;
	localparam logic [1:0] CFG_SKY_LEVEL     = 2'd2;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [2:0] DIR_XP  = 3'd0;
	localparam logic [2:0] DIR_XN  = 3'd1;
	localparam logic [2:0] DIR_YP  = 3'd2;
	localparam logic [2:0] DIR_YN  = 3'd3;
	localparam logic [2:0] DIR_ZP  = 3'd4;
	localparam logic [2:0] DIR_ZN  = 3'd5;
	localparam logic [2:0] DIR_END = 3'd6;

	localparam logic [7:0] RST_EMITTER_ID    = 8'd50;
	localparam logic [3:0] RST_EMITTER_LEVEL = 4'd14;
	localparam logic [3:0] RST_SKY_LEVEL     = 4'd15;

endpackage

@@ rtl/vlff_queue.sv @@
module vlff_queue
	import vlff_pkg::*;
#(
	parameter int AW = 15,
	parameter int DW = 19
) (
	input  logic          clk,
	input  logic          arst_n,
	input  q_ctl_t        ctl,
	input  logic [DW-1:0] push_data,
	output logic [DW-1:0] rd_data,
	output logic          empty
);

	logic [DW-1:0] q_mem [2**AW];
	logic [AW:0]   head_q;
	logic [AW:0]   count_q;
	logic          full;

	assign empty = (head_q == count_q);
	assign full  = count_q[AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctl.clear) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push && !full) count_q <= count_q + (AW+1)'(1);
			if (ctl.pop && !empty) head_q <= head_q + (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && !full) q_mem[count_q[AW-1:0]] <= push_data;
		rd_data <= q_mem[head_q[AW-1:0]];
	end

endmodule

@@ rtl/voxel_light_flood_fill_core.sv @@
// channel  | handshake                  | payload
// in       | in_valid / in_stall        | command, cell_x, cell_y, cell_z, block_id
// out      | out_valid / out_stall      | kind, sky_light, block_light
// cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
// An in-grid write is stored on acceptance; a read passes through the READ state into the output register.
// Compute: wipes both light fields, then reads each seed cell visited and each queued cell;
// a queued cell above level one also reads and checks every in-grid neighbor and skips
// each neighbor off the grid, all on one memory port.
// After reset a pass over all 2^AW addresses (32768 at default size) clears all cell memories;
// no item is taken meanwhile.
// A stalled result holds the output register; new items wait until it can be replaced.
module voxel_light_flood_fill_core
	import vlff_pkg::*;
#(
	parameter int WIDTH_X = 16,
	parameter int WIDTH_Z = 16,
	parameter int HEIGHT  = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [3:0] cell_x,
	input  logic [6:0] cell_y,
	input  logic [3:0] cell_z,
	input  logic [7:0] block_id,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [3:0] sky_light,
	output logic [3:0] block_light,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int XW = $clog2(WIDTH_X);
	localparam int ZW = $clog2(WIDTH_Z);
	localparam int YW = $clog2(HEIGHT);
	localparam int AW = XW + ZW + YW;
	localparam int DW = AW + 4;

	state_t state_q, state_d;

	logic [7:0] emitter_id_q;
	logic [3:0] emitter_level_q;
	logic [3:0] sky_level_q;

	logic [7:0] blk_mem  [2**AW];
	logic [3:0] sky_mem  [2**AW];
	logic [3:0] glow_mem [2**AW];
	logic [7:0] blk_rd;
	logic [3:0] sky_rd;
	logic [3:0] glow_rd;

	logic [AW-1:0] mem_addr;
	logic          blk_we;
	logic [7:0]    blk_wd;
	logic          sky_we;
	logic          glow_we;
	logic [3:0]    lit_wd;

	q_ctl_t        q_ctl;
	logic [DW-1:0] q_wd;
	logic [DW-1:0] q_rd;
	logic          q_empty;

	logic [AW-1:0] ptr_q;
	logic          glow_ph_q;
	logic [XW-1:0] sx_q, cx_q, nx;
	logic [ZW-1:0] sz_q, cz_q, nz;
	logic [YW-1:0] sy_q, cy_q, ny;
	logic [3:0]    lvl_q;
	logic [2:0]    dir_q;
	logic [AW-1:0] naddr_q;
	logic          nb_ok;
	logic          in_grid_q;

	logic          out_valid_q;
	logic          kind_q;
	logic [3:0]    sky_out_q;
	logic [3:0]    blk_out_q;

	logic          in_acc;
	logic          in_grid;
	logic [AW-1:0] in_addr;
	logic [AW-1:0] seed_addr;
	logic [AW-1:0] nb_addr;
	logic          out_free;
	logic          x_last, z_last, col_done, seed_end;
	logic [3:0]    field_rd;
	logic          seed_hit;
	logic          nb_hit;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign in_grid = (int'(cell_x) < WIDTH_X) && (int'(cell_y) < HEIGHT) &&
	                 (int'(cell_z) < WIDTH_Z);
	assign in_addr   = {YW'(cell_y), ZW'(cell_z), XW'(cell_x)};
	assign seed_addr = {sy_q, sz_q, sx_q};
	assign nb_addr   = {ny, nz, nx};

	assign x_last   = (sx_q == XW'(WIDTH_X - 1));
	assign z_last   = (sz_q == ZW'(WIDTH_Z - 1));
	assign col_done = glow_ph_q ? (sy_q == YW'(HEIGHT - 1))
	                            : ((blk_rd != 8'd0) || (sy_q == '0));
	assign seed_end = col_done && x_last && z_last;
	assign seed_hit = glow_ph_q ? (blk_rd == emitter_id_q) : (blk_rd == 8'd0);
	assign field_rd = glow_ph_q ? glow_rd : sky_rd;
	assign nb_hit   = (blk_rd == 8'd0) && (field_rd < (lvl_q - 4'd1));

	always_comb begin
		nx    = cx_q;
		ny    = cy_q;
		nz    = cz_q;
		nb_ok = 1'b0;
		case (dir_q)
			DIR_XP: begin
				nx    = cx_q + XW'(1);
				nb_ok = (cx_q != XW'(WIDTH_X - 1));
			end
			DIR_XN: begin
				nx    = cx_q - XW'(1);
				nb_ok = (cx_q != '0);
			end
			DIR_YP: begin
				ny    = cy_q + YW'(1);
				nb_ok = (cy_q != YW'(HEIGHT - 1));
			end
			DIR_YN: begin
				ny    = cy_q - YW'(1);
				nb_ok = (cy_q != '0);
			end
			DIR_ZP: begin
				nz    = cz_q + ZW'(1);
				nb_ok = (cz_q != ZW'(WIDTH_Z - 1));
			end
			DIR_ZN: begin
				nz    = cz_q - ZW'(1);
				nb_ok = (cz_q != '0);
			end
			default: nb_ok = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: if (&ptr_q) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_acc) begin
					case (command)
						CMD_COMPUTE: state_d = ST_WIPE;
						CMD_READ:    state_d = ST_READ;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ:     state_d = ST_IDLE;
			ST_WIPE:     if (&ptr_q) state_d = ST_SEED_RD;
			ST_SEED_RD:  state_d = ST_SEED_CHK;
			ST_SEED_CHK: state_d = seed_end ? ST_POP : ST_SEED_RD;
			ST_POP: begin
				if (q_empty) begin
					if (glow_ph_q) state_d = ST_DONE;
					else if (emitter_level_q == 4'd0) state_d = ST_POP;
					else state_d = ST_SEED_RD;
				end else begin
					state_d = ST_ENTRY;
				end
			end
			ST_ENTRY: state_d = (q_rd[3:0] <= 4'd1) ? ST_POP : ST_NB_RD;
			ST_NB_RD: begin
				if (dir_q == DIR_END) state_d = ST_POP;
				else if (nb_ok) state_d = ST_NB_CHK;
			end
			ST_NB_CHK: state_d = ST_NB_RD;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_INIT;
		endcase
	end

	always_comb begin
		mem_addr = ptr_q;
		blk_we   = 1'b0;
		blk_wd   = 8'd0;
		sky_we   = 1'b0;
		glow_we  = 1'b0;
		lit_wd   = 4'd0;
		q_ctl    = '0;
		q_wd     = {seed_addr, glow_ph_q ? emitter_level_q : sky_level_q};
		case (state_q)
			ST_INIT: begin
				blk_we  = 1'b1;
				sky_we  = 1'b1;
				glow_we = 1'b1;
			end
			ST_IDLE: begin
				mem_addr = in_addr;
				blk_wd   = block_id;
				blk_we   = in_acc && (command == CMD_WRITE) && in_grid;
				q_ctl.clear = in_acc && (command == CMD_COMPUTE);
			end
			ST_WIPE: begin
				sky_we  = 1'b1;
				glow_we = 1'b1;
			end
			ST_SEED_RD: mem_addr = seed_addr;
			ST_SEED_CHK: begin
				mem_addr   = seed_addr;
				lit_wd     = glow_ph_q ? emitter_level_q : sky_level_q;
				sky_we     = seed_hit && !glow_ph_q;
				glow_we    = seed_hit && glow_ph_q;
				q_ctl.push = seed_hit;
			end
			ST_POP: begin
				q_ctl.pop   = !q_empty;
				q_ctl.clear = q_empty && !glow_ph_q;
			end
			ST_NB_RD: mem_addr = nb_addr;
			ST_NB_CHK: begin
				mem_addr   = naddr_q;
				lit_wd     = lvl_q - 4'd1;
				sky_we     = nb_hit && !glow_ph_q;
				glow_we    = nb_hit && glow_ph_q;
				q_ctl.push = nb_hit;
				q_wd       = {naddr_q, lvl_q - 4'd1};
			end
			default: mem_addr = ptr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (blk_we) blk_mem[mem_addr] <= blk_wd;
		blk_rd <= blk_mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (sky_we) sky_mem[mem_addr] <= lit_wd;
		sky_rd <= sky_mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (glow_we) glow_mem[mem_addr] <= lit_wd;
		glow_rd <= glow_mem[mem_addr];
	end

	vlff_queue #(
		.AW(AW),
		.DW(DW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (q_ctl),
		.push_data(q_wd),
		.rd_data  (q_rd),
		.empty    (q_empty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emitter_id_q    <= RST_EMITTER_ID;
			emitter_level_q <= RST_EMITTER_LEVEL;
			sky_level_q     <= RST_SKY_LEVEL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_EMITTER_ID:    emitter_id_q    <= cfg_data;
				CFG_EMITTER_LEVEL: emitter_level_q <= cfg_data[3:0];
				CFG_SKY_LEVEL:     sky_level_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			ptr_q     <= '0;
			glow_ph_q <= 1'b0;
			sx_q      <= '0;
			sz_q      <= '0;
			sy_q      <= '0;
			dir_q     <= DIR_XP;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_INIT: ptr_q <= ptr_q + AW'(1);
				ST_IDLE: begin
					if (in_acc && (command == CMD_COMPUTE)) begin
						ptr_q     <= '0;
						glow_ph_q <= 1'b0;
					end
				end
				ST_WIPE: begin
					ptr_q <= ptr_q + AW'(1);
					sx_q  <= '0;
					sz_q  <= '0;
					sy_q  <= YW'(HEIGHT - 1);
				end
				ST_SEED_CHK: begin
					if (col_done) begin
						sy_q <= glow_ph_q ? '0 : YW'(HEIGHT - 1);
						if (z_last) begin
							sz_q <= '0;
							sx_q <= sx_q + XW'(1);
						end else begin
							sz_q <= sz_q + ZW'(1);
						end
					end else begin
						sy_q <= glow_ph_q ? sy_q + YW'(1) : sy_q - YW'(1);
					end
				end
				ST_POP: begin
					if (q_empty && !glow_ph_q) begin
						glow_ph_q <= 1'b1;
						sx_q      <= '0;
						sz_q      <= '0;
						sy_q      <= '0;
					end
				end
				ST_ENTRY: dir_q <= DIR_XP;
				ST_NB_RD: if (!nb_ok && (dir_q != DIR_END)) dir_q <= dir_q + 3'd1;
				ST_NB_CHK: dir_q <= dir_q + 3'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ENTRY) begin
			lvl_q <= q_rd[3:0];
			cx_q  <= q_rd[XW+3:4];
			cz_q  <= q_rd[XW+ZW+3:XW+4];
			cy_q  <= q_rd[DW-1:XW+ZW+4];
		end
		if (state_q == ST_NB_RD) naddr_q <= nb_addr;
		if (in_acc) in_grid_q <= in_grid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_READ || (state_q == ST_DONE && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			kind_q    <= KIND_DATA;
			sky_out_q <= in_grid_q ? sky_rd : 4'd0;
			blk_out_q <= in_grid_q ? glow_rd : 4'd0;
		end else if (state_q == ST_DONE && out_free) begin
			kind_q    <= KIND_DONE;
			sky_out_q <= 4'd0;
			blk_out_q <= 4'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign sky_light   = sky_out_q;
	assign block_light = blk_out_q;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctl.pop |-> !q_empty)
		else $error("queue popped while empty");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> out_valid_q && (kind_q == KIND_DATA))
		else $error("read result not presented");

	a_nb_level: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NB_CHK |-> lvl_q > 4'd1)
		else $error("neighbor visited from level below two");

endmodule
